// ----- src/ssp_pkg.sv -----
package ssp_pkg;

  localparam int unsigned TRACKS       = 8;
  localparam int unsigned STEPS        = 16;
  localparam int unsigned VOICES       = 8;
  localparam int unsigned SAMPLE_DEPTH = 4096;

  localparam int unsigned TRK_W  = 3;
  localparam int unsigned STEP_W = 4;
  localparam int unsigned VCE_W  = 3;
  localparam int unsigned ADDR_W = 12;
  localparam int unsigned PAT_N  = TRACKS * STEPS;
  localparam int unsigned PAT_W  = TRK_W + STEP_W;
  localparam int unsigned SMEM_N = TRACKS * SAMPLE_DEPTH;
  localparam int unsigned SMEM_W = TRK_W + ADDR_W;

  localparam int unsigned CNT_W = 37;
  localparam int unsigned SPS_W = 36;
  localparam int unsigned LEN_W = 13;
  localparam int unsigned SPD_W = 20;
  localparam int unsigned POS_W = 32;
  localparam int unsigned SUM_W = 20;
  localparam int unsigned MAG_W = 19;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_PAT   = 3'd1;
  localparam logic [2:0] OP_SMP   = 3'd2;
  localparam logic [2:0] OP_TINFO = 3'd3;
  localparam logic [2:0] OP_START = 3'd4;
  localparam logic [2:0] OP_STOP  = 3'd5;

  localparam logic [1:0] CFG_SPS  = 2'd0;
  localparam logic [1:0] CFG_MUTE = 2'd1;
  localparam logic [1:0] CFG_SOLO = 2'd2;
  localparam logic [1:0] CFG_VOLS = 2'd3;

  localparam logic [SPS_W-1:0] SPS_RESET   = 36'd361267200;
  localparam logic [SPD_W-1:0] SPEED_RESET = 20'd65536;
  localparam logic [CNT_W-1:0] TICK_INC    = 37'd65536;

endpackage

// ----- src/step_sequencer_sample_player_top.sv -----
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    op, track/step/sample/length/speed fields
// out      output     out_valid_o / out_stall_i  mix_out, step_now, voices_active
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// Writes and start/stop are done in the idle state without a stall. A tick steps the
// pattern tracks when a step is due, walks the voices through the sample memory read port
// and, with two or more voices counted, divides the mix bit-serially; the next item is taken
// only once its result has loaded.
// Reset clears control, pattern flags and voices at once; sample memory is not cleared.
// in_stall_o is high while a tick is in work; a held result stalls only the last step.
module step_sequencer_sample_player_top
  import ssp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic [2:0]         track_sel_i,
  input  logic [3:0]         step_sel_i,
  input  logic               step_on_i,
  input  logic [7:0]         step_velocity_i,
  input  logic [11:0]        sample_addr_i,
  input  logic signed [15:0] sample_word_i,
  input  logic [12:0]        length_in_i,
  input  logic [19:0]        speed_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] mix_out_o,
  output logic [3:0]         step_now_o,
  output logic [3:0]         voices_active_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TICK  = 4'd1;
  localparam logic [3:0] S_PRD   = 4'd2;
  localparam logic [3:0] S_FIRE  = 4'd3;
  localparam logic [3:0] S_VCHK  = 4'd4;
  localparam logic [3:0] S_VRD2  = 4'd5;
  localparam logic [3:0] S_VMUL  = 4'd6;
  localparam logic [3:0] S_VGAIN = 4'd7;
  localparam logic [3:0] S_VDIV1 = 4'd8;
  localparam logic [3:0] S_VDIV2 = 4'd9;
  localparam logic [3:0] S_MIX   = 4'd10;
  localparam logic [3:0] S_MDIV  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0]        state_q;
  logic              running_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [STEP_W-1:0] cur_step_q;
  logic [SPS_W-1:0]  sps_q;
  logic [7:0]        mute_q, solo_q;
  logic [63:0]       vols_q;

  logic [PAT_N-1:0]  pat_vld_q;
  logic [8:0]        pat_mem [PAT_N];
  logic [8:0]        pat_rd_q;
  logic              pat_hit_q;
  logic signed [15:0] smem [SMEM_N];
  logic signed [15:0] smem_q;

  logic [LEN_W-1:0]  trk_len_q [TRACKS];
  logic [SPD_W-1:0]  trk_spd_q [TRACKS];
  logic [POS_W-1:0]  v_pos_q   [VOICES];
  logic [SPD_W-1:0]  v_spd_q   [VOICES];
  logic [7:0]        v_gain_q  [VOICES];
  logic [TRK_W-1:0]  v_trk_q   [VOICES];
  logic [VOICES-1:0] v_use_q, v_play_q;

  logic [VCE_W-1:0]   idx_q;
  logic signed [15:0] s1_q, interp_q;
  logic [22:0]        mag_q;
  logic               neg_q;
  logic [15:0]        q0_q;
  logic signed [SUM_W-1:0] sum_q, res_q;
  logic [3:0]         cntv_q;
  logic [MAG_W-1:0]   dq_q;
  logic [3:0]         rem_q;
  logic [4:0]         it_q;

  logic               out_vld_q;
  logic signed [15:0] mix_q;
  logic [3:0]         step_out_q, vact_q;

  logic in_acc;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o     = out_vld_q;
  assign mix_out_o       = mix_q;
  assign step_now_o      = step_out_q;
  assign voices_active_o = vact_q;

  // pattern memory
  logic [PAT_W-1:0] pat_ra;
  logic             pat_we;
  assign pat_ra = {idx_q, cur_step_q};
  assign pat_we = in_acc && op_i == OP_PAT;

  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[{track_sel_i, step_sel_i}] <= {step_on_i, step_velocity_i};
    end
    pat_rd_q <= pat_mem[pat_ra];
  end

  // sample memory
  logic [TRK_W-1:0]  cur_trk;
  logic [15:0]       cur_pos;
  logic [15:0]       rd_pos;
  logic [SMEM_W-1:0] smem_ra;
  logic              smem_we;
  assign cur_trk = v_trk_q[idx_q];
  assign cur_pos = v_pos_q[idx_q][31:16];
  assign rd_pos  = (state_q == S_VRD2) ? cur_pos + 16'd1 : cur_pos;
  assign smem_ra = {cur_trk, rd_pos[ADDR_W-1:0]};
  assign smem_we = in_acc && op_i == OP_SMP;

  always_ff @(posedge clk_i) begin
    if (smem_we) begin
      smem[{track_sel_i, sample_addr_i}] <= sample_word_i;
    end
    smem_q <= smem[smem_ra];
  end

  // trigger: voice pick and gain
  logic [VCE_W-1:0] pick;
  logic             found;
  logic [15:0]      gprod;
  logic [16:0]      gsum;
  logic [7:0]       gain_new;
  logic             fire;

  always_comb begin
    pick  = '0;
    found = 1'b0;
    for (int v = 0; v < VOICES; v++) begin
      if (!found && !v_use_q[v]) begin
        pick  = VCE_W'(v);
        found = 1'b1;
      end
    end
    for (int v = 0; v < VOICES; v++) begin
      if (!found && v_trk_q[v] == idx_q) begin
        pick  = VCE_W'(v);
        found = 1'b1;
      end
    end
  end

  assign gprod    = 16'(pat_rd_q[7:0]) * 16'(vols_q[8*idx_q +: 8]);
  assign gsum     = 17'(gprod) + 17'(gprod >> 8) + 17'd1;
  assign gain_new = gsum[15:8];
  assign fire = pat_hit_q && pat_rd_q[8] && trk_len_q[idx_q] != '0 && !mute_q[idx_q]
                && !(solo_q != '0 && !solo_q[idx_q]);

  // voice datapath
  logic [LEN_W-1:0]   cur_len;
  logic               v_stop;
  logic signed [16:0] diff;
  logic signed [33:0] iprod;
  logic signed [17:0] isum;
  logic signed [24:0] vprod;
  logic [24:0]        vmag;
  logic [38:0]        recip;
  logic [23:0]        q255, rr;
  logic [15:0]        qfix;
  logic signed [SUM_W-1:0] contrib;

  assign cur_len = trk_len_q[cur_trk];
  assign v_stop  = (cur_len < LEN_W'(2)) || (cur_pos >= 16'(cur_len - LEN_W'(1)));
  assign diff    = 17'(smem_q) - 17'(s1_q);
  assign iprod   = diff * $signed({17'd0, v_pos_q[idx_q][15:0]});
  assign isum    = 18'(s1_q) + iprod[33:16];
  assign vprod   = interp_q * $signed({17'd0, v_gain_q[idx_q]});
  assign vmag    = vprod[24] ? 25'(-vprod) : 25'(vprod);
  assign recip   = {1'b0, mag_q, 15'd0} + {9'd0, mag_q, 7'd0};
  assign q255    = {q0_q, 8'd0} - 24'(q0_q);
  assign rr      = {1'b0, mag_q} - q255;
  assign qfix    = (rr >= 24'd255) ? q0_q + 16'd1 : q0_q;
  assign contrib = neg_q ? -SUM_W'(qfix) : SUM_W'(qfix);

  // mix divider
  logic [4:0]        dtry;
  logic              dbit;
  logic [MAG_W-1:0]  dq_n;
  logic [SUM_W-1:0]  sum_abs;
  assign dtry    = {rem_q, dq_q[MAG_W-1]};
  assign dbit    = dtry >= {1'b0, cntv_q};
  assign dq_n    = {dq_q[MAG_W-2:0], dbit};
  assign sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  logic signed [15:0] sat;
  always_comb begin
    if (res_q > SUM_W'(32767)) begin
      sat = 16'sd32767;
    end else if (res_q < -SUM_W'(32768)) begin
      sat = -16'sd32768;
    end else begin
      sat = res_q[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      running_q  <= 1'b0;
      cnt_q      <= '0;
      cur_step_q <= '0;
      sps_q      <= SPS_RESET;
      mute_q     <= '0;
      solo_q     <= '0;
      vols_q     <= '1;
      pat_vld_q  <= '0;
      pat_hit_q  <= 1'b0;
      v_use_q    <= '0;
      v_play_q   <= '0;
      for (int i = 0; i < TRACKS; i++) begin
        trk_len_q[i] <= '0;
        trk_spd_q[i] <= SPEED_RESET;
      end
      for (int v = 0; v < VOICES; v++) begin
        v_pos_q[v]  <= '0;
        v_spd_q[v]  <= '0;
        v_gain_q[v] <= '0;
        v_trk_q[v]  <= '0;
      end
      idx_q     <= '0;
      cntv_q    <= '0;
      sum_q     <= '0;
      it_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      // a new result in the final step takes over the slot itself
      if (out_vld_q && !out_stall_i && state_q != S_DONE) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_SPS:  sps_q  <= cfg_data_i[SPS_W-1:0];
          CFG_MUTE: mute_q <= cfg_data_i[7:0];
          CFG_SOLO: solo_q <= cfg_data_i[7:0];
          CFG_VOLS: vols_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (op_i)
              OP_TICK: begin
                if (running_q) begin
                  state_q <= S_TICK;
                end
              end
              OP_PAT: pat_vld_q[{track_sel_i, step_sel_i}] <= 1'b1;
              OP_TINFO: begin
                trk_len_q[track_sel_i] <= (length_in_i > LEN_W'(SAMPLE_DEPTH)) ?
                                          LEN_W'(SAMPLE_DEPTH) : length_in_i;
                trk_spd_q[track_sel_i] <= speed_in_i;
              end
              OP_START: begin
                cur_step_q <= '0;
                cnt_q      <= '0;
                running_q  <= 1'b1;
              end
              OP_STOP: begin
                running_q  <= 1'b0;
                cur_step_q <= '0;
                cnt_q      <= '0;
                v_use_q    <= '0;
                v_play_q   <= '0;
                for (int v = 0; v < VOICES; v++) begin
                  v_pos_q[v] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_TICK: begin
          idx_q  <= '0;
          sum_q  <= '0;
          cntv_q <= '0;
          if (cnt_q >= CNT_W'(sps_q)) begin
            cnt_q   <= cnt_q - CNT_W'(sps_q);
            state_q <= S_PRD;
          end else begin
            state_q <= S_VCHK;
          end
        end
        S_PRD: begin
          // pattern data lands next cycle
          pat_hit_q <= pat_vld_q[pat_ra];
          state_q   <= S_FIRE;
        end
        S_FIRE: begin
          if (fire) begin
            v_pos_q[pick]  <= '0;
            v_spd_q[pick]  <= trk_spd_q[idx_q];
            v_gain_q[pick] <= gain_new;
            v_trk_q[pick]  <= idx_q;
            v_use_q[pick]  <= 1'b1;
            v_play_q[pick] <= 1'b1;
          end
          if (idx_q == TRK_W'(TRACKS - 1)) begin
            cur_step_q <= (cur_step_q == STEP_W'(STEPS - 1)) ? '0 : cur_step_q + 1'b1;
            idx_q      <= '0;
            state_q    <= S_VCHK;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_PRD;
          end
        end
        S_VCHK: begin
          if (v_use_q[idx_q] && v_play_q[idx_q] && !v_stop) begin
            state_q <= S_VRD2;
          end else begin
            if (v_use_q[idx_q]) begin
              if (v_play_q[idx_q]) begin
                // ran off the end: silent but still counted
                v_play_q[idx_q] <= 1'b0;
                cntv_q          <= cntv_q + 1'b1;
              end else begin
                v_use_q[idx_q] <= 1'b0;
              end
            end
            if (idx_q == VCE_W'(VOICES - 1)) begin
              state_q <= S_MIX;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        S_VRD2: begin
          s1_q    <= smem_q;
          state_q <= S_VMUL;
        end
        S_VMUL: begin
          interp_q       <= isum[15:0];
          v_pos_q[idx_q] <= v_pos_q[idx_q] + POS_W'(v_spd_q[idx_q]);
          state_q        <= S_VGAIN;
        end
        S_VGAIN: begin
          mag_q   <= vmag[22:0];
          neg_q   <= vprod[24];
          state_q <= S_VDIV1;
        end
        S_VDIV1: begin
          q0_q    <= recip[38:23];
          state_q <= S_VDIV2;
        end
        S_VDIV2: begin
          sum_q  <= sum_q + contrib;
          cntv_q <= cntv_q + 1'b1;
          if (idx_q == VCE_W'(VOICES - 1)) begin
            state_q <= S_MIX;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_VCHK;
          end
        end
        S_MIX: begin
          if (cntv_q > 4'd1) begin
            dq_q    <= sum_abs[MAG_W-1:0];
            neg_q   <= sum_q[SUM_W-1];
            rem_q   <= '0;
            it_q    <= '0;
            state_q <= S_MDIV;
          end else begin
            res_q   <= sum_q;
            state_q <= S_DONE;
          end
        end
        S_MDIV: begin
          dq_q  <= dq_n;
          rem_q <= dbit ? 4'(dtry - {1'b0, cntv_q}) : dtry[3:0];
          it_q  <= it_q + 1'b1;
          if (it_q == 5'(MAG_W - 1)) begin
            res_q   <= neg_q ? -SUM_W'(dq_n) : SUM_W'(dq_n);
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_vld_q || !out_stall_i) begin
            out_vld_q  <= 1'b1;
            mix_q      <= sat;
            step_out_q <= cur_step_q;
            vact_q     <= cntv_q;
            cnt_q      <= cnt_q + TICK_INC;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_play_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_play_q & ~v_use_q) == '0)
    else $error("voice playing without being in use");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cntv_q <= 4'(VOICES))
    else $error("active voice count out of range");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the final step");

  a_div_only_multi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MDIV |-> cntv_q > 4'd1)
    else $error("mix divide with count below two");

  a_tick_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TICK |-> running_q)
    else $error("tick processed while stopped");
`endif

endmodule
